### rtl/wpi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpi_pkg: shared types and constants of the weighted interpolator
// Request and result structs, status codes and the coefficient table.
// ----------------------------------------------------------------------------
package wpi_pkg;

	localparam int LANES   = 4;
	localparam int VAL_W   = 32;
	localparam int COEF_W  = 7;
	localparam int PROD_W  = VAL_W + COEF_W + 1;   // one lane's c*v
	localparam int ACC_W   = PROD_W + 2;           // sum over the lanes
	localparam int SQ_W    = 11;                   // c*c, at most 1225
	localparam int TNUM_W  = SQ_W + 24;            // c*c shifted by 24
	localparam int TERM_W  = TNUM_W;               // one lane's quotient
	localparam int SUM_W   = TERM_W + 2;           // sum of the terms
	localparam int RNUM_W  = 33;                   // holds 2^32
	localparam int LANE_LAT = TNUM_W;              // one stage per quotient bit

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NODATA   = 2'd1,
		ST_INVALID  = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [LANES-1:0][COEF_W-1:0] coef_vec_t;

	typedef struct packed {
		logic [2:0]        sample_count;
		logic [2:0]        target_position;
		logic signed [31:0] sample_value_0;
		logic signed [31:0] sample_value_1;
		logic signed [31:0] sample_value_2;
		logic signed [31:0] sample_value_3;
		logic [31:0]       sample_weight_0;
		logic [31:0]       sample_weight_1;
		logic [31:0]       sample_weight_2;
		logic [31:0]       sample_weight_3;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [31:0]       result_weight;
		status_t           status;
	} res_t;

	function automatic coef_vec_t mk_coef(input int c0, input int c1, input int c2,
		input int c3);
		coef_vec_t r;
		r[0] = COEF_W'(c0);
		r[1] = COEF_W'(c1);
		r[2] = COEF_W'(c2);
		r[3] = COEF_W'(c3);
		return r;
	endfunction

	// Lagrange weights in sixteenths, by sample count and gap position
	function automatic coef_vec_t coef_lookup(input logic [2:0] n, input logic [2:0] m);
		coef_vec_t r;
		unique case ({n, m})
			{3'd1, 3'd0}: r = mk_coef(16, 0, 0, 0);
			{3'd1, 3'd1}: r = mk_coef(16, 0, 0, 0);
			{3'd2, 3'd0}: r = mk_coef(24, -8, 0, 0);
			{3'd2, 3'd1}: r = mk_coef(8, 8, 0, 0);
			{3'd2, 3'd2}: r = mk_coef(-8, 24, 0, 0);
			{3'd3, 3'd0}: r = mk_coef(30, -20, 6, 0);
			{3'd3, 3'd1}: r = mk_coef(6, 12, -2, 0);
			{3'd3, 3'd2}: r = mk_coef(-2, 12, 6, 0);
			{3'd3, 3'd3}: r = mk_coef(6, -20, 30, 0);
			{3'd4, 3'd0}: r = mk_coef(35, -35, 21, -5);
			{3'd4, 3'd1}: r = mk_coef(5, 15, -5, 1);
			{3'd4, 3'd2}: r = mk_coef(-1, 9, 9, -1);
			{3'd4, 3'd3}: r = mk_coef(1, -5, 15, 5);
			{3'd4, 3'd4}: r = mk_coef(-5, 21, -35, 35);
			default:      r = mk_coef(0, 0, 0, 0);
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/wpi_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpi_div: pipelined restoring divider
// One quotient bit per stage, MSB first; side data rides along unchanged.
// ----------------------------------------------------------------------------
module wpi_div #(
	parameter int NW = 35,
	parameter int DW = 32,
	parameter int SW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	output logic [NW-1:0]      quo,
	output logic [SW-1:0]      side_out
);
	logic          v_q    [NW+1];
	logic [DW-1:0] rem_q  [NW+1];
	logic [NW-1:0] num_q  [NW+1];
	logic [NW-1:0] quo_q  [NW+1];
	logic [DW-1:0] den_q  [NW+1];
	logic [SW-1:0] side_q [NW+1];

	assign v_q[0]    = in_valid;
	assign rem_q[0]  = '0;
	assign num_q[0]  = num;
	assign quo_q[0]  = '0;
	assign den_q[0]  = den;
	assign side_q[0] = side_in;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW:0]   trial;
		logic          ge;
		logic [DW:0]   diff;
		assign trial = {rem_q[i], num_q[i][NW-1]};
		assign ge    = trial >= {1'b0, den_q[i]};
		assign diff  = trial - {1'b0, den_q[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else begin
				v_q[i+1] <= v_q[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_q[i+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			num_q[i+1]  <= num_q[i] << 1;
			quo_q[i+1]  <= {quo_q[i][NW-2:0], ge};
			den_q[i+1]  <= den_q[i];
			side_q[i+1] <= side_q[i];
		end
	end

	assign out_valid = v_q[NW];
	assign quo       = quo_q[NW];
	assign side_out  = side_q[NW];
endmodule
`default_nettype wire

### rtl/wpi_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpi_lane: one sample lane
// Forms c*v and the weight term floor(c*c*2^24 / w) for one sample.
// ----------------------------------------------------------------------------
module wpi_lane (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire wpi_pkg::coef_t                 coef,
	input  wire logic signed [wpi_pkg::VAL_W-1:0] value,
	input  wire logic [31:0]                    den,
	output logic                                out_valid,
	output logic signed [wpi_pkg::PROD_W-1:0]   prod,
	output logic [wpi_pkg::TERM_W-1:0]          term
);
	import wpi_pkg::*;

	logic signed [PROD_W-1:0] prod_in;
	logic [SQ_W-1:0]          sq;
	logic [PROD_W-1:0]        prod_raw;

	assign prod_in = PROD_W'(coef) * PROD_W'(value);
	assign sq      = SQ_W'(SQ_W'(coef) * SQ_W'(coef));

	wpi_div #(.NW(TNUM_W), .DW(32), .SW(PROD_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.num      ({sq, 24'd0}),
		.den      (den),
		.side_in  (prod_in),
		.out_valid(out_valid),
		.quo      (term),
		.side_out (prod_raw)
	);

	assign prod = signed'(prod_raw);
endmodule
`default_nettype wire

### rtl/wpi_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpi_merge: lane merge and final reciprocal
// Sums the lanes, checks range, divides 2^32 by the term sum.
// ----------------------------------------------------------------------------
module wpi_merge (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire wpi_pkg::status_t             status_in,
	input  wire logic [wpi_pkg::LANES-1:0][wpi_pkg::PROD_W-1:0] prods,
	input  wire logic [wpi_pkg::LANES-1:0][wpi_pkg::TERM_W-1:0] terms,
	output logic                              result_valid,
	output wpi_pkg::res_t                     result
);
	import wpi_pkg::*;

	logic signed [ACC_W-1:0] acc_c;
	logic [SUM_W-1:0]        sum_c;
	logic signed [ACC_W-1:0] acc_s1;
	logic [SUM_W-1:0]        sum_s1;
	status_t                 st_s1;
	logic                    v_s1;
	logic                    vovf;
	logic                    sovf;
	status_t                 st_div;
	logic                    d_valid;
	logic [RNUM_W-1:0]       d_quo;
	logic [VAL_W+1:0]        d_side;
	status_t                 st_out;

	always_comb begin
		acc_c = '0;
		sum_c = '0;
		for (int k = 0; k < LANES; k++) begin
			acc_c = acc_c + ACC_W'(signed'(prods[k]));
			sum_c = sum_c + SUM_W'(terms[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		acc_s1 <= acc_c;
		sum_s1 <= sum_c;
		st_s1  <= status_in;
	end

	// floor(acc/16) must fit 32 bits signed
	assign vovf = acc_s1[ACC_W-1:VAL_W+3] != {(ACC_W-VAL_W-3){acc_s1[VAL_W+3]}};
	// sum of zero or one, or above 2^32, leaves no 32-bit reciprocal
	assign sovf = (sum_s1 < SUM_W'(2)) || (|sum_s1[SUM_W-1:33])
		|| (sum_s1[32] && (|sum_s1[31:0]));

	always_comb begin
		priority if (st_s1 != ST_OK) begin
			st_div = st_s1;
		end else if (vovf || sovf) begin
			st_div = ST_OVERFLOW;
		end else begin
			st_div = ST_OK;
		end
	end

	wpi_div #(.NW(RNUM_W), .DW(RNUM_W), .SW(VAL_W + 2)) u_rcp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.num      ({1'b1, 32'd0}),
		.den      (sum_s1[RNUM_W-1:0]),
		.side_in  ({st_div, acc_s1[VAL_W+3:4]}),
		.out_valid(d_valid),
		.quo      (d_quo),
		.side_out (d_side)
	);

	assign st_out = status_t'(d_side[VAL_W+1:VAL_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		result.status        <= st_out;
		result.result_value  <= (st_out == ST_OK) ? signed'(d_side[VAL_W-1:0]) : '0;
		result.result_weight <= (st_out == ST_OK) ? d_quo[31:0] : '0;
	end
endmodule
`default_nettype wire

### rtl/weighted_poly_interpolator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_poly_interpolator_core: weighted equispaced Lagrange interpolator
// Up to four weighted samples in, one value and propagated weight out.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy stays low, so a
// new request may follow in the very next cycle. Each request yields exactly
// one result, shown for a single cycle under result_valid; the receiver must
// take it then, as it cannot be held. A request passes a decode stage, the
// two bit-serial divider pipelines (35 stages in each sample lane for the
// weight terms and 33 stages for the final reciprocal) with a merge stage
// between them, and then the output register.
// ----------------------------------------------------------------------------
module weighted_poly_interpolator_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire wpi_pkg::req_t req,
	output logic               result_valid,
	output wpi_pkg::res_t      result
);
	import wpi_pkg::*;

	localparam int TOTAL_LAT = 1 + LANE_LAT + 1 + RNUM_W + 1;

	logic                           take;
	logic [LANES-1:0][VAL_W-1:0]    vals;
	logic [LANES-1:0][31:0]         wgts;
	coef_vec_t                      coefs;
	logic                           zero_w;
	status_t                        st_c;

	logic                           v_s1;
	status_t                        st_s1;
	coef_vec_t                      coef_s1;
	logic [LANES-1:0][VAL_W-1:0]    val_s1;
	logic [LANES-1:0][31:0]         den_s1;

	logic [LANES-1:0]               lane_v;
	logic [LANES-1:0][PROD_W-1:0]   lane_prod;
	logic [LANES-1:0][TERM_W-1:0]   lane_term;
	status_t                        st_dly_q [LANE_LAT];

	// never stalls: every cycle can take a request
	assign busy = 1'b0;
	assign take = start && !busy;

	assign vals  = {req.sample_value_3, req.sample_value_2,
		req.sample_value_1, req.sample_value_0};
	assign wgts  = {req.sample_weight_3, req.sample_weight_2,
		req.sample_weight_1, req.sample_weight_0};
	assign coefs = coef_lookup(req.sample_count, req.target_position);

	// a zero weight only matters among the samples in use
	always_comb begin
		zero_w = 1'b0;
		for (int k = 0; k < LANES; k++) begin
			if ((3'(k) < req.sample_count) && (wgts[k] == '0)) begin
				zero_w = 1'b1;
			end
		end
	end

	always_comb begin
		priority if (req.sample_count == 3'd0) begin
			st_c = ST_NODATA;
		end else if ((req.sample_count > 3'(LANES))
			|| (req.target_position > req.sample_count) || zero_w) begin
			st_c = ST_INVALID;
		end else begin
			st_c = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	// Decode stage. A lane with a zero coefficient divides zero by one so its
	// term comes out zero whatever its weight holds.
	always_ff @(posedge clk) begin
		st_s1   <= st_c;
		coef_s1 <= coefs;
		val_s1  <= vals;
		for (int k = 0; k < LANES; k++) begin
			den_s1[k] <= (coefs[k] == '0) ? 32'd1 : wgts[k];
		end
	end

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		logic signed [PROD_W-1:0] p;
		wpi_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_s1),
			.coef     (signed'(coef_s1[k])),
			.value    (signed'(val_s1[k])),
			.den      (den_s1[k]),
			.out_valid(lane_v[k]),
			.prod     (p),
			.term     (lane_term[k])
		);
		assign lane_prod[k] = p;
	end

	// carry the early status alongside the lane dividers
	always_ff @(posedge clk) begin
		st_dly_q[0] <= st_s1;
		for (int i = 1; i < LANE_LAT; i++) begin
			st_dly_q[i] <= st_dly_q[i-1];
		end
	end

	wpi_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (&lane_v),
		.status_in   (st_dly_q[LANE_LAT-1]),
		.prods       (lane_prod),
		.terms       (lane_term),
		.result_valid(result_valid),
		.result      (result)
	);

	// a failed request never carries a value or weight
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.status != ST_OK))
		|-> ((result.result_value == '0) && (result.result_weight == '0)))
		else $error("non-ok result carries data");

	// a good result always has a nonzero weight
	a_weight_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.status == ST_OK)) |-> (result.result_weight != '0))
		else $error("ok result with zero weight");

	// a result only ever follows a request by the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(take, TOTAL_LAT))
		else $error("result without matching request");
endmodule
`default_nettype wire
